### src/kwm_pkg.sv
// Package for the k-way merge block: sizes, controller state and the
// structs passed between the top level and the head cells. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kwm_pkg;

    localparam int LISTS       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int ID_W        = 4;                    // list_id / source_list field
    localparam int CFG_W       = 5;                    // num_lists field
    localparam int IDX_W       = $clog2(LISTS);        // cell index
    localparam int CNT_W       = $clog2(LISTS + 1);    // holds LISTS itself

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SWEEP
    } t_state;

    // running minimum handed from cell to cell
    typedef struct packed {
        logic                          found;
        logic signed [VALUE_WIDTH-1:0] value;
        logic [IDX_W-1:0]              idx;
    } t_best;

    // per-cell control from the controller
    typedef struct packed {
        logic                          load;
        logic                          gone;
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          clear;
        logic                          pop;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### src/kwm_ifs.sv
// Valid/ready channel interfaces for the k-way merge block.
// Depends on kwm_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface kwm_in_if
    import kwm_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic [ID_W-1:0]               list_id;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          exhausted;

    modport source (output valid, output list_id, output value, output exhausted,
                    input ready);
    modport sink   (input valid, input list_id, input value, input exhausted,
                    output ready);
endinterface

interface kwm_out_if
    import kwm_pkg::*;
;
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] min_value;
    logic [ID_W-1:0]               source_list;
    logic                          done_res;

    modport source (output valid, output min_value, output source_list,
                    output done_res, input ready);
    modport sink   (input valid, input min_value, input source_list,
                    input done_res, output ready);
endinterface

`default_nettype wire

### src/k_way_min_heap_merge.sv
// K-way merge of sorted streams: load/refill controller, output register
// and the chain of head cells. Uses kwm_pkg, kwm_ifs and kwm_cell.
//
// Usage:
//   i_item carries list_id, value and exhausted. o_res carries min_value,
//   source_list and done_res. i_cfg_we/i_cfg_data write num_lists and
//   restart the merge; write only while the block is idle.
//   The first num_lists items load the heads; only the last of them gives
//   a result, and each later refill gives one. After a done result
//   further items are dropped until reset or a num_lists write.
// Sweep:
//   An item that causes a result starts a sweep: the running minimum
//   moves through the LISTS-cell chain of registered cells, then the
//   result is registered.
//   Items with a list_id outside the lists in use are dropped.
// Reset (synchronous, active low) clears all valid bits and counters and
// sets num_lists to 16. If o_res is stalled, the finished sweep waits and
// i_item stays not ready; a held result does not block a following load.
`timescale 1ns / 1ps
`default_nettype none

module k_way_min_heap_merge
    import kwm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    kwm_in_if.sink                i_item,
    kwm_out_if.source             o_res
);

    t_state                        r_state;
    t_state                        n_state;
    logic [CFG_W-1:0]              r_num_lists;
    logic [CNT_W-1:0]              r_loaded;
    logic [CNT_W-1:0]              n_loaded;
    logic [CNT_W-1:0]              r_cnt;
    logic [CNT_W-1:0]              n_cnt;
    logic                          r_finished;
    logic                          n_finished;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_min;
    logic [ID_W-1:0]               r_src;
    logic                          r_done;
    logic                          out_load;

    logic [CNT_W-1:0]              n_use;
    logic                          accept;
    logic                          use_item;
    logic                          pop;
    t_best                         chain [LISTS+1];
    t_cell_ctrl                    ctrl [LISTS];
    t_best                         final_best;

    // lists in use, num_lists clamped to 1..LISTS
    always_comb begin
        if (r_num_lists == '0) begin
            n_use = CNT_W'(1);
        end else if (int'(r_num_lists) > LISTS) begin
            n_use = CNT_W'(LISTS);
        end else begin
            n_use = CNT_W'(r_num_lists);
        end
    end

    assign i_item.ready = (r_state == ST_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign use_item     = accept && !r_finished && (int'(i_item.list_id) < int'(n_use));
    assign final_best   = chain[LISTS];

    always_comb begin
        n_state     = r_state;
        n_loaded    = r_loaded;
        n_cnt       = r_cnt;
        n_finished  = r_finished;
        n_out_valid = r_out_valid;
        out_load    = 1'b0;
        pop         = 1'b0;

        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (use_item) begin
                    if (r_loaded < n_use) begin
                        n_loaded = r_loaded + CNT_W'(1);
                        if (n_loaded >= n_use) begin
                            n_state = ST_SWEEP;
                        end
                    end else begin
                        n_state = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP: begin
                if (r_cnt != CNT_W'(LISTS)) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (!r_out_valid || o_res.ready) begin
                    // chain has settled and the output register is free
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    if (final_best.found) begin
                        pop = 1'b1;
                    end else begin
                        n_finished = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a num_lists write restarts the merge
        if (i_cfg_we) begin
            n_loaded   = '0;
            n_finished = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_num_lists <= CFG_W'(16);
            r_loaded    <= '0;
            r_cnt       <= '0;
            r_finished  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_loaded    <= n_loaded;
            r_cnt       <= n_cnt;
            r_finished  <= n_finished;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_num_lists <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (final_best.found) begin
                r_min  <= final_best.value;
                r_src  <= ID_W'(final_best.idx);
                r_done <= 1'b0;
            end else begin
                r_min  <= '0;
                r_src  <= '0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.min_value   = r_min;
    assign o_res.source_list = r_src;
    assign o_res.done_res    = r_done;

    assign chain[0] = '0;

    for (genvar k = 0; k < LISTS; k++) begin : g_cell
        always_comb begin
            ctrl[k].load  = use_item && (int'(i_item.list_id) == k);
            ctrl[k].gone  = i_item.exhausted;
            ctrl[k].value = i_item.value;
            ctrl[k].clear = i_cfg_we;
            ctrl[k].pop   = pop && (int'(final_best.idx) == k);
        end

        kwm_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_idx  (IDX_W'(k)),
            .i_ctrl (ctrl[k]),
            .i_best (chain[k]),
            .o_best (chain[k+1])
        );
    end

endmodule

`default_nettype wire

### src/kwm_cell.sv
// One head cell: holds the head of one list and its valid bit, and folds
// its head into the running minimum passed down the chain. Uses kwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kwm_cell
    import kwm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire t_cell_ctrl       i_ctrl,
    input  wire t_best            i_best,
    output t_best                 o_best
);

    logic                          r_valid;
    logic signed [VALUE_WIDTH-1:0] r_head;
    t_best                         r_best;
    t_best                         n_best;
    logic                          take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load) begin
            r_valid <= !i_ctrl.gone;
        end else if (i_ctrl.pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && !i_ctrl.gone) begin
            r_head <= i_ctrl.value;
        end
    end

    // strict less-than keeps the lower list on a tie
    always_comb begin
        take = r_valid && (!i_best.found || (r_head < i_best.value));
        if (take) begin
            n_best.found = 1'b1;
            n_best.value = r_head;
            n_best.idx   = i_idx;
        end else begin
            n_best = i_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best.found <= 1'b0;
        end else begin
            r_best.found <= n_best.found;
        end
        r_best.value <= n_best.value;
        r_best.idx   <= n_best.idx;
    end

    assign o_best = r_best;

endmodule

`default_nettype wire
